// ===== src/rcli_pkg.sv =====
package rcli_pkg;

    localparam int LINE_MAX_DEF    = 15;
    localparam int RELAY_COUNT_DEF = 6;
    localparam int RELAY_W         = 6;
    localparam int QUEUE_DEPTH     = 2;
    localparam int IDX_W           = 5;

    localparam logic [7:0] STREAM_LENGTH_RESET = 8'd60;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;

    localparam int MSG_START_LEN = 14;
    localparam int MSG_STOP_LEN  = 13;
    localparam int MSG_OK_LEN    = 5;

    localparam logic [8*MSG_START_LEN-1:0] MSG_START = {"STREAM START", CH_CR, CH_LF};
    localparam logic [8*MSG_STOP_LEN-1:0]  MSG_STOP  = {"STREAM STOP", CH_CR, CH_LF};
    localparam logic [8*MSG_OK_LEN-1:0]    MSG_OK    = {" OK", CH_CR, CH_LF};

    // Input item kinds.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Reply kinds handed from the front to the back.
    localparam logic [1:0] KIND_START     = 2'd0;
    localparam logic [1:0] KIND_RELAY     = 2'd1;
    localparam logic [1:0] KIND_PINS      = 2'd2;
    localparam logic [1:0] KIND_PINS_STOP = 2'd3;

    localparam int PINS_LEN = 6;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic [3:0] pin_levels;
    } item_t;

    typedef struct packed {
        logic [7:0]         tx_byte;
        logic               last;
        logic [RELAY_W-1:0] relay_bits;
    } reply_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         digit;
        logic               value;
        logic [3:0]         pins;
        logic [RELAY_W-1:0] relay_bits;
    } job_t;

    function automatic logic [IDX_W-1:0] reply_len(logic [1:0] kind);
        logic [IDX_W-1:0] n;
        unique case (kind)
            KIND_START: n = IDX_W'(MSG_START_LEN);
            KIND_RELAY: n = IDX_W'(4 + MSG_OK_LEN);
            KIND_PINS:  n = IDX_W'(PINS_LEN);
            default:    n = IDX_W'(PINS_LEN + MSG_STOP_LEN);
        endcase
        return n;
    endfunction

    function automatic logic [7:0] reply_byte(job_t j, logic [IDX_W-1:0] idx);
        logic [7:0] b;
        int         i;
        b = CH_NUL;
        i = int'(idx);
        unique case (j.kind)
            KIND_START:
            begin
                if (i < MSG_START_LEN)
                    b = MSG_START[8*(MSG_START_LEN-1-i) +: 8];
            end
            KIND_RELAY:
            begin
                priority if (i == 0)
                    b = CH_R;
                else if (i == 1)
                    b = j.digit;
                else if (i == 2)
                    b = CH_COMMA;
                else if (i == 3)
                    b = j.value ? CH_ONE : CH_ZERO;
                else if (i < 4 + MSG_OK_LEN)
                    b = MSG_OK[8*(MSG_OK_LEN-1-(i-4)) +: 8];
            end
            default:
            begin
                // A low pin is active and reads as a one.
                priority if (i < 4)
                    b = j.pins[idx[1:0]] ? CH_ZERO : CH_ONE;
                else if (i == 4)
                    b = CH_CR;
                else if (i == 5)
                    b = CH_LF;
                else if (i < PINS_LEN + MSG_STOP_LEN)
                    b = MSG_STOP[8*(MSG_STOP_LEN-1-(i-PINS_LEN)) +: 8];
            end
        endcase
        return b;
    endfunction

endpackage

// ===== src/relay_command_line_interpreter_top.sv =====
// Channel    Direction  Handshake                 Payload
// item       in         item_valid / item_ready   rcli_pkg::item_t
// reply      out        reply_valid / reply_ready rcli_pkg::reply_t
// config     in         cfg_we (no wait)          cfg_wdata (stream length)
//
// An item is decoded in the cycle of its transfer; its reply text is queued as one job.
// Reply stage: one byte per cycle unless stalled; 6, 9, 14 or 19 bytes by reply kind.
// A two-entry job queue lets items be taken while the reply stage is still sending.
// No-reply items queue no job. Reset clears all control state; length resets to 60.
// A stall on reply holds the output byte; item_ready drops only when the queue is full.
module relay_command_line_interpreter_top #(
    parameter int LINE_MAX    = rcli_pkg::LINE_MAX_DEF,
    parameter int RELAY_COUNT = rcli_pkg::RELAY_COUNT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    input  logic             item_valid,
    output logic             item_ready,
    input  rcli_pkg::item_t  item,
    output logic             reply_valid,
    input  logic             reply_ready,
    output rcli_pkg::reply_t reply
);
    import rcli_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_nonempty;
    job_t q_push_job;
    job_t q_head;

    rcli_front #(
        .LINE_MAX    (LINE_MAX),
        .RELAY_COUNT (RELAY_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_push_job (q_push_job)
    );

    rcli_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .head_job (q_head)
    );

    rcli_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_nonempty  (q_nonempty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .reply_valid (reply_valid),
        .reply_ready (reply_ready),
        .reply       (reply)
    );

endmodule

// ===== src/rcli_front.sv =====
module rcli_front #(
    parameter int LINE_MAX    = 15,
    parameter int RELAY_COUNT = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    input  logic             item_valid,
    output logic             item_ready,
    input  rcli_pkg::item_t  item,
    input  logic             q_full,
    output logic             q_push,
    output rcli_pkg::job_t   q_push_job
);
    import rcli_pkg::*;

    localparam int CNT_W = $clog2(LINE_MAX + 1);

    logic [7:0]         head_reg [4];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [RELAY_W-1:0] relay_reg, relay_next;
    logic [3:0]         last_pins_reg, last_pins_next;
    logic               reported_reg, reported_next;
    logic               stream_reg, stream_next;
    logic [7:0]         left_reg, left_next;
    logic [7:0]         length_reg;

    logic       accept;
    logic       head_we;
    logic [1:0] head_idx;
    logic [7:0] head_wdata;
    logic [7:0] eff [4];
    logic       is_eol;
    logic       match_start;
    logic       match_relay;
    logic [3:0] relay_sel;

    assign item_ready = !q_full;
    assign accept     = item_valid && item_ready;
    assign is_eol     = (item.rx_byte == CH_CR) || (item.rx_byte == CH_LF);
    assign head_idx   = count_reg[1:0];

    // The head as it reads after the line end writes its terminating zero.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (count_reg < CNT_W'(4) && head_idx == 2'(i))
                eff[i] = CH_NUL;
            else
                eff[i] = head_reg[i];
        end
    end

    assign match_start = (eff[0] == CH_S) && (eff[1] == CH_T) && (eff[2] == CH_R)
                         && (eff[3] == CH_NUL);
    assign match_relay = (eff[0] == CH_R) && (eff[1] >= CH_ONE)
                         && (eff[1] <= 8'(32'h30 + RELAY_COUNT))
                         && (eff[2] == CH_COMMA)
                         && ((eff[3] == CH_ZERO) || (eff[3] == CH_ONE));
    assign relay_sel   = eff[1][3:0] - 4'd1;

    always_comb
    begin
        count_next      = count_reg;
        relay_next      = relay_reg;
        last_pins_next  = last_pins_reg;
        reported_next   = reported_reg;
        stream_next     = stream_reg;
        left_next       = left_reg;
        head_we         = 1'b0;
        head_wdata      = item.rx_byte;
        q_push          = 1'b0;
        q_push_job      = '0;
        q_push_job.digit = eff[1];
        q_push_job.value = eff[3][0];
        q_push_job.pins  = item.pin_levels;

        if (accept)
        begin
            if (item.command == CMD_BYTE)
            begin
                if (!stream_reg)
                begin
                    priority if (is_eol)
                    begin
                        head_we    = count_reg < CNT_W'(4);
                        head_wdata = CH_NUL;
                        count_next = '0;
                        if (match_start)
                        begin
                            q_push          = 1'b1;
                            q_push_job.kind = KIND_START;
                            stream_next     = 1'b1;
                            left_next       = length_reg;
                        end
                        else if (match_relay)
                        begin
                            q_push          = 1'b1;
                            q_push_job.kind = KIND_RELAY;
                            for (int i = 0; i < RELAY_W; i++)
                            begin
                                if (relay_sel == 4'(i))
                                    relay_next[i] = eff[3][0];
                            end
                        end
                    end
                    else if (count_reg < CNT_W'(LINE_MAX))
                    begin
                        head_we    = count_reg < CNT_W'(4);
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        count_next = '0;
                    end
                end
            end
            else if (stream_reg)
            begin
                q_push = 1'b1;
                if (left_reg <= 8'd1)
                begin
                    q_push_job.kind = KIND_PINS_STOP;
                    stream_next     = 1'b0;
                    left_next       = '0;
                end
                else
                begin
                    q_push_job.kind = KIND_PINS;
                    left_next       = left_reg - 8'd1;
                end
            end
            else if (!reported_reg || item.pin_levels != last_pins_reg)
            begin
                q_push          = 1'b1;
                q_push_job.kind = KIND_PINS;
                last_pins_next  = item.pin_levels;
                reported_next   = 1'b1;
            end
        end
        q_push_job.relay_bits = relay_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            relay_reg     <= '0;
            last_pins_reg <= '0;
            reported_reg  <= 1'b0;
            stream_reg    <= 1'b0;
            left_reg      <= '0;
            length_reg    <= STREAM_LENGTH_RESET;
        end
        else
        begin
            count_reg     <= count_next;
            relay_reg     <= relay_next;
            last_pins_reg <= last_pins_next;
            reported_reg  <= reported_next;
            stream_reg    <= stream_next;
            left_reg      <= left_next;
            if (cfg_we)
                length_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_reg[head_idx] <= head_wdata;
    end

endmodule

// ===== src/rcli_queue.sv =====
module rcli_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rcli_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output logic            nonempty,
    output rcli_pkg::job_t  head_job
);
    import rcli_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = cnt_reg == CNT_W'(QUEUE_DEPTH);
    assign nonempty = cnt_reg != '0;
    assign head_job = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        if (pop)
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_job;
    end

endmodule

// ===== src/rcli_back.sv =====
module rcli_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_nonempty,
    input  rcli_pkg::job_t   q_head,
    output logic             q_pop,
    output logic             reply_valid,
    input  logic             reply_ready,
    output rcli_pkg::reply_t reply
);
    import rcli_pkg::*;

    job_t             job_reg, job_next;
    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    reply_t           out_reg, out_next;

    logic advance;
    logic send;
    logic is_last;
    logic finish;

    assign advance = !out_valid_reg || reply_ready;
    assign send    = busy_reg && advance;
    assign is_last = idx_reg == reply_len(job_reg.kind) - IDX_W'(1);
    assign finish  = send && is_last;
    assign q_pop   = q_nonempty && (!busy_reg || finish);

    assign reply_valid = out_valid_reg;
    assign reply       = out_reg;

    always_comb
    begin
        job_next       = job_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (advance)
        begin
            out_valid_next = send;
            if (send)
            begin
                out_next.tx_byte    = reply_byte(job_reg, idx_reg);
                out_next.last       = is_last;
                out_next.relay_bits = job_reg.relay_bits;
            end
        end

        priority if (q_pop)
        begin
            job_next  = q_head;
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        else if (send)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

endmodule
